[hdl/hbec_pkg.sv]
package hbec_pkg;

  // Default largest board edge
  localparam int MAX_SIDE_DEF = 16;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 4;
  localparam int CELL_W     = 8;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIR_W      = 3;
  localparam int EPOCH_W    = 8;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE  = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0] BOARD_SIZE_RST  = 5'd11;
  localparam logic [CELL_W-1:0] CURSOR_MASK_RST = 8'd128;
  localparam logic [CELL_W-1:0] EMPTY_CODE_RST  = 8'd0;

  // First and last of the six neighbor directions
  localparam logic [DIR_W-1:0] DIR_FIRST = 3'd0;
  localparam logic [DIR_W-1:0] DIR_LAST  = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [CELL_W-1:0]  cell_value;
    logic               check_side;
  } in_t;

  typedef struct packed {
    logic won;
    logic winner_side;
  } out_t;

  // One hex step: each coordinate moves up, down or stays
  typedef struct packed {
    logic x_inc;
    logic x_dec;
    logic y_inc;
    logic y_dec;
  } hex_step_t;

  // Offsets (0,1) (1,-1) (1,0) (-1,0) (-1,1) (0,-1)
  function automatic hex_step_t hex_step(input logic [DIR_W-1:0] dir);
    hex_step_t s;
    s = '0;
    case (dir)
      3'd0: s.y_inc = 1'b1;
      3'd1: begin
        s.x_inc = 1'b1;
        s.y_dec = 1'b1;
      end
      3'd2: s.x_inc = 1'b1;
      3'd3: s.x_dec = 1'b1;
      3'd4: begin
        s.x_dec = 1'b1;
        s.y_inc = 1'b1;
      end
      3'd5: s.y_dec = 1'b1;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

[hdl/hbec_ram.sv]
module hbec_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/hex_board_edge_connection_check.sv]
// Hex board edge-connection checker.
// Input channel (in_valid/in_ready/in_data) takes one transaction per item:
// clear the board, write one cell, or check for a win from a cell. Only a
// check returns a result on the output channel (out_valid/out_ready/out_data).
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high, and writes are meant for an idle block.
// Sequence: a write stores its cell without leaving S_IDLE. A clear sweeps the
// used board, one cell a cycle. A check reads the start cell, then for each
// stone of the chain pops it and tries its six neighbors in turn, skipping an
// off-board neighbor and reading the board cell and visit mark of an on-board
// one, and at the end registers the result in the output register in S_RES.
// Visit marks hold the number of the check that set them; after reset and
// after every 255th check a pass over all MAX_SIDE*MAX_SIDE marks (256 by
// default) zeroes them while in_ready stays low.
// Reset restores the registers to size 11, cursor mask 128, empty code 0;
// board contents are undefined until cleared.
// A stalled receiver holds the result in the output register; the next item
// is still taken, and a finishing check waits until the register drains.
module hex_board_edge_connection_check #(
  parameter int MAX_SIDE = hbec_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hbec_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hbec_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hbec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbec_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hbec_pkg::*;

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(MAX_SIDE);
  localparam int NW    = $clog2(MAX_SIDE + 1);
  localparam int CMPW  = (NW > SIZE_W) ? NW : SIZE_W;
  localparam int CNTW  = AW + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_CLEAR = 9'b0_0000_0010,
    S_START = 9'b0_0000_0100,
    S_POP   = 9'b0_0000_1000,
    S_POPW  = 9'b0_0001_0000,
    S_NB    = 9'b0_0010_0000,
    S_NBW   = 9'b0_0100_0000,
    S_RES   = 9'b0_1000_0000,
    S_VCLR  = 9'b1_0000_0000
  } state_t;

  function automatic logic [AW-1:0] idx_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(y) * AW'(MAX_SIDE) + AW'(x);
  endfunction

  state_t             state_r, state_nxt;
  logic [SIZE_W-1:0]  board_size_r;
  logic [CELL_W-1:0]  cursor_mask_r, empty_code_r;
  logic [CW-1:0]      cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CW-1:0]      clr_x_r, clr_x_nxt, clr_y_r, clr_y_nxt;
  logic [DIR_W-1:0]   dir_r, dir_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [CELL_W-1:0]  stone_r, stone_nxt;
  logic               near_r, near_nxt, far_r, far_nxt, side_r, side_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]      vclr_r, vclr_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [CMPW-1:0]    n_size, last;
  logic [CMPW-1:0]    in_xc, in_yc;
  logic               in_on_board, in_acc;
  logic [CW-1:0]      in_x, in_y;

  logic               brd_we, brd_re;
  logic [AW-1:0]      brd_waddr, brd_raddr;
  logic [CELL_W-1:0]  brd_wdata, brd_rdata, brd_stone, stone_mask;
  logic               stk_we, stk_re;
  logic [AW-1:0]      stk_waddr, stk_raddr;
  logic [2*CW-1:0]    stk_wdata, stk_rdata;
  logic [CW-1:0]      pop_x, pop_y;
  logic               vis_we, vis_re;
  logic [AW-1:0]      vis_waddr;
  logic [EPOCH_W-1:0] vis_wdata, vis_rdata;

  hex_step_t          step;
  logic [CW-1:0]      nb_x, nb_y;
  logic               nb_ok;
  logic [AW-1:0]      nb_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r  <= BOARD_SIZE_RST;
      cursor_mask_r <= CURSOR_MASK_RST;
      empty_code_r  <= EMPTY_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOARD_SIZE:  board_size_r  <= cfg_data[SIZE_W-1:0];
        CFG_CURSOR_MASK: cursor_mask_r <= cfg_data;
        CFG_EMPTY_CODE:  empty_code_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Clamp the board size and decode the incoming cell
  assign n_size      = (CMPW'(board_size_r) > CMPW'(MAX_SIDE)) ? CMPW'(MAX_SIDE)
                                                               : CMPW'(board_size_r);
  assign last        = n_size - CMPW'(1);
  assign in_xc       = CMPW'(in_data.cell_x);
  assign in_yc       = CMPW'(in_data.cell_y);
  assign in_on_board = (in_xc < n_size) && (in_yc < n_size);
  assign in_x        = CW'(in_xc);
  assign in_y        = CW'(in_yc);
  assign in_ready    = (state_r == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign stone_mask  = ~cursor_mask_r;
  assign brd_stone   = brd_rdata & stone_mask;
  assign pop_x       = stk_rdata[CW-1:0];
  assign pop_y       = stk_rdata[2*CW-1:CW];

  // Neighbor of the current stone in the current direction
  always_comb begin
    step  = hex_step(dir_r);
    nb_x  = cur_x_r;
    nb_y  = cur_y_r;
    nb_ok = 1'b1;
    if (step.x_inc) begin
      nb_x  = cur_x_r + CW'(1);
      nb_ok = nb_ok && ((CMPW'(cur_x_r) + CMPW'(1)) < n_size);
    end
    if (step.x_dec) begin
      nb_x  = cur_x_r - CW'(1);
      nb_ok = nb_ok && (cur_x_r != '0);
    end
    if (step.y_inc) begin
      nb_y  = cur_y_r + CW'(1);
      nb_ok = nb_ok && ((CMPW'(cur_y_r) + CMPW'(1)) < n_size);
    end
    if (step.y_dec) begin
      nb_y  = cur_y_r - CW'(1);
      nb_ok = nb_ok && (cur_y_r != '0);
    end
    nb_idx = idx_of(nb_x, nb_y);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    clr_x_nxt     = clr_x_r;
    clr_y_nxt     = clr_y_r;
    dir_nxt       = dir_r;
    cnt_nxt       = cnt_r;
    stone_nxt     = stone_r;
    near_nxt      = near_r;
    far_nxt       = far_r;
    side_nxt      = side_r;
    epoch_nxt     = epoch_r;
    vclr_nxt      = vclr_r;
    vis_we        = 1'b0;
    vis_re        = 1'b0;
    vis_waddr     = nb_idx;
    vis_wdata     = epoch_r;
    brd_we        = 1'b0;
    brd_waddr     = idx_of(in_x, in_y);
    brd_wdata     = in_data.cell_value;
    brd_re        = 1'b0;
    brd_raddr     = nb_idx;
    stk_we        = 1'b0;
    stk_waddr     = cnt_r[AW-1:0];
    stk_wdata     = {nb_y, nb_x};
    stk_re        = 1'b0;
    stk_raddr     = AW'(cnt_r - CNTW'(1));
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            KIND_CLEAR: begin
              clr_x_nxt = '0;
              clr_y_nxt = '0;
              if (n_size != '0) begin
                state_nxt = S_CLEAR;
              end
            end
            KIND_WRITE: begin
              brd_we = in_on_board;
            end
            KIND_CHECK: begin
              // A fresh check number retires all earlier visit marks
              epoch_nxt = epoch_r + EPOCH_W'(1);
              near_nxt  = 1'b0;
              far_nxt   = 1'b0;
              side_nxt  = in_data.check_side;
              cur_x_nxt = in_x;
              cur_y_nxt = in_y;
              if (in_on_board) begin
                brd_re    = 1'b1;
                brd_raddr = idx_of(in_x, in_y);
                state_nxt = S_START;
              end else begin
                state_nxt = S_RES;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        brd_we    = 1'b1;
        brd_waddr = idx_of(clr_x_r, clr_y_r);
        brd_wdata = empty_code_r;
        if (CMPW'(clr_x_r) == last) begin
          clr_x_nxt = '0;
          clr_y_nxt = clr_y_r + CW'(1);
          if (CMPW'(clr_y_r) == last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_x_nxt = clr_x_r + CW'(1);
        end
      end
      S_START: begin
        if (brd_stone == empty_code_r) begin
          state_nxt = S_RES;
        end else begin
          stone_nxt = brd_stone;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {cur_y_r, cur_x_r};
          cnt_nxt   = CNTW'(1);
          vis_we    = 1'b1;
          vis_waddr = idx_of(cur_x_r, cur_y_r);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (cnt_r == '0) begin
          state_nxt = S_RES;
        end else begin
          stk_re    = 1'b1;
          cnt_nxt   = cnt_r - CNTW'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cur_x_nxt = pop_x;
        cur_y_nxt = pop_y;
        if (side_r) begin
          near_nxt = near_r || (pop_y == '0);
          far_nxt  = far_r || (CMPW'(pop_y) == last);
        end else begin
          near_nxt = near_r || (pop_x == '0);
          far_nxt  = far_r || (CMPW'(pop_x) == last);
        end
        vis_we    = 1'b1;
        vis_waddr = idx_of(pop_x, pop_y);
        dir_nxt   = DIR_FIRST;
        state_nxt = S_NB;
      end
      S_NB: begin
        // Read the neighbor's cell and visit mark together
        if (nb_ok) begin
          brd_re    = 1'b1;
          vis_re    = 1'b1;
          state_nxt = S_NBW;
        end else if (dir_r == DIR_LAST) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + DIR_W'(1);
        end
      end
      S_NBW: begin
        // Push a matching unvisited neighbor
        if (brd_stone == stone_r && vis_rdata != epoch_r && cnt_r != CNTW'(CELLS)) begin
          vis_we  = 1'b1;
          stk_we  = 1'b1;
          cnt_nxt = cnt_r + CNTW'(1);
        end
        if (dir_r == DIR_LAST) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + DIR_W'(1);
          state_nxt = S_NB;
        end
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.won         = near_r && far_r;
          out_data_nxt.winner_side = near_r && far_r && side_r;
          if (epoch_r == '1) begin
            state_nxt = S_VCLR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_VCLR: begin
        // Zero every visit mark, after reset and before the check number wraps
        vis_we    = 1'b1;
        vis_waddr = vclr_r;
        vis_wdata = '0;
        if (vclr_r == AW'(CELLS - 1)) begin
          vclr_nxt  = '0;
          epoch_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          vclr_nxt = vclr_r + AW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_VCLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      epoch_r     <= '0;
      vclr_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      epoch_r     <= epoch_nxt;
      vclr_r      <= vclr_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    clr_x_r    <= clr_x_nxt;
    clr_y_r    <= clr_y_nxt;
    dir_r      <= dir_nxt;
    stone_r    <= stone_nxt;
    near_r     <= near_nxt;
    far_r      <= far_nxt;
    side_r     <= side_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hbec_ram #(
    .W     (CELL_W),
    .DEPTH (CELLS)
  ) u_board (
    .clk     (clk),
    .wr_en   (brd_we),
    .wr_addr (brd_waddr),
    .wr_data (brd_wdata),
    .rd_en   (brd_re),
    .rd_addr (brd_raddr),
    .rd_data (brd_rdata)
  );

  hbec_ram #(
    .W     (2 * CW),
    .DEPTH (CELLS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  hbec_ram #(
    .W     (EPOCH_W),
    .DEPTH (CELLS)
  ) u_visit (
    .clk     (clk),
    .wr_en   (vis_we),
    .wr_addr (vis_waddr),
    .wr_data (vis_wdata),
    .rd_en   (vis_re),
    .rd_addr (nb_idx),
    .rd_data (vis_rdata)
  );

endmodule

[hdl/hbec_checker.sv]
module hbec_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input hbec_pkg::in_t                    in_data,
  input logic                             out_valid,
  input logic                             out_ready,
  input hbec_pkg::out_t                   out_data
);
  import hbec_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Drop results at reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Report a side only on a win
  a_side_won: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.winner_side |-> out_data.won)
    else $error("winner side without win");

  // Go busy after taking a check
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_CHECK |=> !in_ready)
    else $error("check did not occupy the block");

endmodule

bind hex_board_edge_connection_check hbec_checker u_hbec_checker (.*);

[tb/hex_board_edge_connection_check_tb.sv]
`timescale 1ns / 1ps

module hex_board_edge_connection_check_tb;
  import hbec_pkg::*;

  localparam int SIDE    = MAX_SIDE_DEF;
  localparam int CELLS   = SIDE * SIDE;
  localparam int N_ITEMS = 1450;

  // Board mirror with its own flood fill; holds expected win results in order
  class win_scoreboard;
    logic [CELL_W-1:0] cells [CELLS];
    bit                seen [CELLS];
    int                stack_x [CELLS];
    int                stack_y [CELLS];
    int                board_size;
    logic [CELL_W-1:0] cursor_mask;
    logic [CELL_W-1:0] empty_code;
    out_t              wins_due [$];
    int                errors;

    function new();
      board_size  = BOARD_SIZE_RST;
      cursor_mask = CURSOR_MASK_RST;
      empty_code  = EMPTY_CODE_RST;
      errors      = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BOARD_SIZE:  board_size = val[SIZE_W-1:0];
        CFG_CURSOR_MASK: cursor_mask = val;
        CFG_EMPTY_CODE:  empty_code = val;
        default: ;
      endcase
    endfunction

    function int used();
      return (board_size > SIDE) ? SIDE : board_size;
    endfunction

    function logic [CELL_W-1:0] stone(int x, int y);
      return cells[y * SIDE + x] & ~cursor_mask;
    endfunction

    // Flood fill over the six hex neighbors from the start cell
    function bit edge_joined(int sx, int sy, bit side);
      int n, depth, x, y, nx, ny;
      int dx [6];
      int dy [6];
      logic [CELL_W-1:0] s;
      bit near_hit, far_hit;
      dx = '{0, 1, 1, -1, -1, 0};
      dy = '{1, -1, 0, 0, 1, -1};
      n = used();
      near_hit = 0;
      far_hit = 0;
      foreach (seen[i]) seen[i] = 0;
      if (sx >= n || sy >= n) return 0;
      s = stone(sx, sy);
      if (s == empty_code) return 0;
      stack_x[0] = sx;
      stack_y[0] = sy;
      depth = 1;
      while (depth > 0) begin
        depth--;
        x = stack_x[depth];
        y = stack_y[depth];
        if (side) begin
          if (y == 0) near_hit = 1;
          if (y == n - 1) far_hit = 1;
        end else begin
          if (x == 0) near_hit = 1;
          if (x == n - 1) far_hit = 1;
        end
        seen[y * SIDE + x] = 1;
        for (int d = 0; d < 6; d++) begin
          nx = x + dx[d];
          ny = y + dy[d];
          if (nx < 0 || ny < 0 || nx >= n || ny >= n) continue;
          if (stone(nx, ny) == s && !seen[ny * SIDE + nx] && depth < CELLS) begin
            seen[ny * SIDE + nx] = 1;
            stack_x[depth] = nx;
            stack_y[depth] = ny;
            depth++;
          end
        end
      end
      return near_hit && far_hit;
    endfunction

    function void note_input(in_t t);
      int n;
      out_t r;
      n = used();
      case (t.kind)
        KIND_CLEAR: begin
          for (int j = 0; j < n; j++)
            for (int i = 0; i < n; i++) cells[j * SIDE + i] = empty_code;
        end
        KIND_WRITE: begin
          if (t.cell_x < n && t.cell_y < n) cells[t.cell_y * SIDE + t.cell_x] = t.cell_value;
        end
        KIND_CHECK: begin
          r.won = edge_joined(t.cell_x, t.cell_y, t.check_side);
          r.winner_side = r.won ? t.check_side : 1'b0;
          wins_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (wins_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result won=%0b side=%0b", got.won,
                                   got.winner_side);
        return;
      end
      want = wins_due.pop_front();
      if (got.won !== want.won || got.winner_side !== want.winner_side) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected won=%0b side=%0b, got won=%0b side=%0b",
                   want.won, want.winner_side, got.won, got.winner_side);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  win_scoreboard sb;
  bit            gaps_on;
  int            stall_left;
  logic [CELL_W-1:0] palette [3];

  hex_board_edge_connection_check DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send_item(in_t t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(t);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for all results, then let a trailing clear finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.wins_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic in_t make_item(logic [KIND_W-1:0] k, int x, int y,
                                    logic [CELL_W-1:0] v, bit s);
    in_t t;
    t.kind = k;
    t.cell_x = COORD_W'(x);
    t.cell_y = COORD_W'(y);
    t.cell_value = v;
    t.check_side = s;
    return t;
  endfunction

  // Random transaction biased toward chains of a few stones on the used board
  function automatic in_t rand_item();
    int n, pick;
    in_t t;
    n = sb.used();
    t = make_item(KIND_WRITE, 0, 0, '0, 1'($urandom_range(0, 1)));
    t.cell_x = COORD_W'((n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
                                                             : $urandom_range(0, 15));
    t.cell_y = COORD_W'((n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
                                                             : $urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 55) t.kind = KIND_WRITE;
    else if (pick < 92) t.kind = KIND_CHECK;
    else if (pick < 96) t.kind = KIND_CLEAR;
    else t.kind = KIND_UNUSED;
    if ($urandom_range(0, 9) == 0) t.cell_value = CELL_W'($urandom_range(0, 255));
    else t.cell_value = palette[$urandom_range(0, 2)] |
                        (sb.cursor_mask & CELL_W'($urandom_range(0, 255)));
    return t;
  endfunction

  task automatic run_phase(int bsize, int mask, int empty, int count);
    write_reg(CFG_BOARD_SIZE, CFG_DATA_W'(bsize));
    write_reg(CFG_CURSOR_MASK, CFG_DATA_W'(mask));
    write_reg(CFG_EMPTY_CODE, CFG_DATA_W'(empty));
    palette[0] = CELL_W'(empty);
    palette[1] = CELL_W'($urandom_range(0, 255));
    palette[2] = CELL_W'($urandom_range(0, 255));
    send_item(make_item(KIND_CLEAR, 0, 0, 0, 0));
    for (int i = 0; i < count; i++) send_item(rand_item());
    drain();
  endtask

  initial begin
    int left;
    sb = new();
    gaps_on = 1'b1;
    stall_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BOARD_SIZE;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default registers, empty and off-board checks, a full row chain
    send_item(make_item(KIND_CLEAR, 0, 0, 8'hFF, 1));
    send_item(make_item(KIND_CHECK, 3, 3, 0, 1));
    send_item(make_item(KIND_CHECK, 15, 15, 0, 1));
    for (int i = 0; i < 11; i++) send_item(make_item(KIND_WRITE, i, 5, 8'h81, 0));
    send_item(make_item(KIND_WRITE, 12, 2, 8'h01, 1));
    send_item(make_item(KIND_WRITE, 4, 15, 8'hFF, 0));
    send_item(make_item(KIND_UNUSED, 15, 15, 8'hFF, 1));
    send_item(make_item(KIND_CHECK, 0, 5, 0, 0));
    send_item(make_item(KIND_CHECK, 10, 5, 0, 1));
    send_item(make_item(KIND_CHECK, 7, 5, 8'hFF, 0));
    drain();

    // Extremes, one-cell board, empty board, oversized board, then random settings
    run_phase(16, 0, 0, 110);
    run_phase(1, 128, 0, 40);
    run_phase(0, 255, 255, 30);
    run_phase(20, 255, 7, 60);
    run_phase(2, 8'h0F, 8'h30, 80);
    left = N_ITEMS - 325 - 20;
    while (left > 0) begin
      if (left < 200) gaps_on = 1'b0;
      run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8),
                $urandom_range(0, 255), $urandom_range(0, 255), 100);
      left -= 101;
    end

    if (sb.errors == 0 && sb.wins_due.size() == 0) begin
      $display("hex_board_edge_connection_check_tb: clean");
    end else begin
      $display("hex_board_edge_connection_check_tb: errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("hex_board_edge_connection_check_tb: errors");
    $finish;
  end

endmodule
